// File: design/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer and its channels.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int MSG_OP_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0]  CFG_IS_CLIENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_MSG   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MAX_MSG_RESET = 32'd1048576;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;
    localparam logic [3:0] OP_DATA_MAX = 4'd2;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_PAY
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_DATA,
        EV_EMPTY_END,
        EV_PONG,
        EV_BAD_OPCODE,
        EV_UNMASKED,
        EV_TOO_LONG
    } t_event;

    typedef struct packed {
        t_event                ev;
        logic [BYTE_W-1:0]     data;
        logic [MSG_OP_W-1:0]   op;
        logic                  last;
    } t_result;

endpackage

// File: design/wsd_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_rx_if
// Received byte channel: valid/ready handshake carrying one byte per transfer.
// ----------------------------------------------------------------------------
interface wsd_rx_if;
    logic                      valid;
    logic                      ready;
    logic [wsd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/wsd_ev_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ev_if
// Event channel: valid/ready handshake carrying one deframer event per transfer.
// ----------------------------------------------------------------------------
interface wsd_ev_if;
    logic                        valid;
    logic                        ready;
    logic [wsd_pkg::EVENT_W-1:0]  event_res;
    logic [wsd_pkg::BYTE_W-1:0]   data_byte;
    logic [wsd_pkg::MSG_OP_W-1:0] message_opcode;
    logic                        last_of_message;

    modport source (output valid, output event_res, output data_byte,
                    output message_opcode, output last_of_message, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input message_opcode, input last_of_message, output ready);
endinterface

// File: design/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses received WebSocket frames one byte per cycle when the event output is
// not stalled: header, extended length and mask key are consumed, payload
// bytes of data frames come out unmasked with the message opcode, control frame
// payloads are skipped, a ping raises a pong request and a protocol error raises
// an error event and closes the block until reset. Each byte passes an input
// register, then a result register; the per-byte step is a single pass whose
// longest path is the 65-bit message length add and limit compare on the last
// length byte. A stalled event output holds the next byte in the input register
// and then back-pressures the byte channel.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
    parameter int MSG_LEN_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    wsd_rx_if.sink                             i_rx,
    wsd_ev_if.source                           o_ev
);

    logic                             r_is_client;
    logic [wsd_pkg::CFG_DATA_W-1:0]   r_max_msg;

    logic                             r_in_valid;
    logic [7:0]                       r_in_byte;
    logic                             r_out_valid;
    wsd_pkg::t_result                 r_out;
    wsd_pkg::t_result                 n_out;

    wsd_pkg::t_phase                  r_phase, n_phase;
    logic                             r_fin, n_fin;
    logic [3:0]                       r_opcode, n_opcode;
    logic                             r_masked, n_masked;
    logic [2:0]                       r_bcnt, n_bcnt;
    logic [63:0]                      r_remain, n_remain;
    logic [31:0]                      r_key, n_key;
    logic [1:0]                       r_kidx, n_kidx;
    logic [1:0]                       r_msg_op, n_msg_op;
    logic [MSG_LEN_WIDTH-1:0]         r_msg_len, n_msg_len;
    logic                             r_closed, n_closed;

    logic        advance;
    logic        step;
    logic        emit;
    logic        is_data;
    logic        bad_opcode;
    logic        lk_go;
    logic        sp_go;
    logic        pong_go;
    logic        lk_masked;
    logic [63:0] ext_remain;
    logic [63:0] lk_remain;
    logic [64:0] lk_sum;
    logic        too_long;
    logic [7:0]  key_byte;

    assign advance    = !r_out_valid || o_ev.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    assign is_data    = (r_opcode <= wsd_pkg::OP_DATA_MAX);
    assign bad_opcode = !is_data && ((r_opcode < wsd_pkg::OP_CLOSE) ||
                                     (r_opcode > wsd_pkg::OP_PONG));
    assign ext_remain = {r_remain[55:0], r_in_byte};
    assign lk_remain  = (r_phase == wsd_pkg::PH_HDR1) ? {57'd0, r_in_byte[6:0]} : ext_remain;
    assign lk_masked  = (r_phase == wsd_pkg::PH_HDR1) ? r_in_byte[7] : r_masked;
    assign lk_sum     = 65'(r_msg_len) + {1'b0, lk_remain};
    assign too_long   = (|(lk_sum >> MSG_LEN_WIDTH)) ||
                        (lk_sum[63:0] >= {32'd0, r_max_msg});
    assign key_byte   = r_key[{~r_kidx, 3'b000} +: 8];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_client <= 1'b0;
            r_max_msg   <= wsd_pkg::MAX_MSG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wsd_pkg::CFG_IS_CLIENT: r_is_client <= i_cfg_data[0];
                wsd_pkg::CFG_MAX_MSG:   r_max_msg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte parse step
    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_bcnt    = r_bcnt;
        n_remain  = r_remain;
        n_key     = r_key;
        n_kidx    = r_kidx;
        n_msg_op  = r_msg_op;
        n_msg_len = r_msg_len;
        n_closed  = r_closed;
        emit      = 1'b0;
        lk_go     = 1'b0;
        sp_go     = 1'b0;
        pong_go   = 1'b0;
        n_out     = '{ev: wsd_pkg::EV_DATA, data: 8'd0, op: 2'd0, last: 1'b0};

        if (step && !r_closed) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    n_fin    = r_in_byte[7];
                    n_opcode = r_in_byte[3:0];
                    n_phase  = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1: begin
                    n_masked = r_in_byte[7];
                    n_key    = 32'd0;
                    n_kidx   = 2'd0;
                    if (bad_opcode) begin
                        n_closed = 1'b1;
                        emit     = 1'b1;
                        n_out.ev = wsd_pkg::EV_BAD_OPCODE;
                    end else if (is_data && !r_is_client && !r_in_byte[7]) begin
                        n_closed = 1'b1;
                        emit     = 1'b1;
                        n_out.ev = wsd_pkg::EV_UNMASKED;
                    end else begin
                        if (is_data && (r_opcode != wsd_pkg::OP_CONT) && (r_msg_op == 2'd0)) begin
                            n_msg_op = r_opcode[1:0];
                        end
                        n_remain = 64'd0;
                        if (r_in_byte[6:0] == wsd_pkg::LEN16_CODE) begin
                            n_bcnt  = 3'd1;
                            n_phase = wsd_pkg::PH_EXT;
                        end else if (r_in_byte[6:0] == wsd_pkg::LEN64_CODE) begin
                            n_bcnt  = 3'd7;
                            n_phase = wsd_pkg::PH_EXT;
                        end else begin
                            lk_go = 1'b1;
                        end
                        pong_go = (r_opcode == wsd_pkg::OP_PING);
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_remain = ext_remain;
                    if (r_bcnt == 3'd0) begin
                        lk_go = 1'b1;
                    end else begin
                        n_bcnt = r_bcnt - 3'd1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key = {r_key[23:0], r_in_byte};
                    if (r_bcnt == 3'd0) begin
                        sp_go = 1'b1;
                    end else begin
                        n_bcnt = r_bcnt - 3'd1;
                    end
                end
                wsd_pkg::PH_PAY: begin
                    n_kidx   = r_kidx + 2'd1;
                    n_remain = r_remain - 64'd1;
                    if (r_remain == 64'd1) begin
                        n_phase = wsd_pkg::PH_HDR0;
                    end
                    if (is_data) begin
                        emit       = 1'b1;
                        n_out.ev   = wsd_pkg::EV_DATA;
                        n_out.data = r_in_byte ^ key_byte;
                        n_out.op   = r_msg_op;
                        n_out.last = r_fin && (r_remain == 64'd1);
                        if (n_out.last) begin
                            n_msg_op  = 2'd0;
                            n_msg_len = '0;
                        end
                    end
                end
                default: begin
                    n_phase = wsd_pkg::PH_HDR0;
                end
            endcase

            // frame length known
            if (lk_go) begin
                n_remain = lk_remain;
                if (is_data && too_long) begin
                    n_closed = 1'b1;
                    emit     = 1'b1;
                    n_out.ev = wsd_pkg::EV_TOO_LONG;
                end else begin
                    if (is_data) begin
                        n_msg_len = lk_sum[MSG_LEN_WIDTH-1:0];
                    end
                    if (lk_masked) begin
                        n_phase = wsd_pkg::PH_KEY;
                        n_bcnt  = 3'd3;
                    end else begin
                        sp_go = 1'b1;
                    end
                end
            end

            // header done, payload starts
            if (sp_go) begin
                n_kidx = 2'd0;
                if (n_remain != 64'd0) begin
                    n_phase = wsd_pkg::PH_PAY;
                end else begin
                    n_phase = wsd_pkg::PH_HDR0;
                    if (is_data && r_fin) begin
                        emit       = 1'b1;
                        n_out.ev   = wsd_pkg::EV_EMPTY_END;
                        n_out.op   = n_msg_op;
                        n_out.last = 1'b1;
                        n_msg_op   = 2'd0;
                        n_msg_len  = '0;
                    end
                end
            end

            if (pong_go) begin
                emit  = 1'b1;
                n_out = '{ev: wsd_pkg::EV_PONG, data: 8'd0, op: 2'd0, last: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= wsd_pkg::PH_HDR0;
            r_fin       <= 1'b0;
            r_opcode    <= 4'd0;
            r_masked    <= 1'b0;
            r_bcnt      <= 3'd0;
            r_remain    <= 64'd0;
            r_key       <= 32'd0;
            r_kidx      <= 2'd0;
            r_msg_op    <= 2'd0;
            r_msg_len   <= '0;
            r_closed    <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_out_valid <= step && emit;
            end
            r_phase   <= n_phase;
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_masked  <= n_masked;
            r_bcnt    <= n_bcnt;
            r_remain  <= n_remain;
            r_key     <= n_key;
            r_kidx    <= n_kidx;
            r_msg_op  <= n_msg_op;
            r_msg_len <= n_msg_len;
            r_closed  <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_ev.valid           = r_out_valid;
    assign o_ev.event_res       = r_out.ev;
    assign o_ev.data_byte       = r_out.data;
    assign o_ev.message_opcode  = r_out.op;
    assign o_ev.last_of_message = r_out.last;

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("closed state left without reset");

    a_close_reports_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_closed) |-> (r_out_valid &&
            ((r_out.ev == wsd_pkg::EV_BAD_OPCODE) ||
             (r_out.ev == wsd_pkg::EV_UNMASKED) ||
             (r_out.ev == wsd_pkg::EV_TOO_LONG))))
        else $error("block closed without an error event");

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsd_pkg::PH_PAY) |-> (r_remain != 64'd0))
        else $error("payload phase with no bytes remaining");

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_closed && o_ev.ready) |=> !r_out_valid)
        else $error("event produced while closed");

endmodule

// File: tb/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking bench for the frame deframer. Byte streams of well-formed
// messages go in, with random reserved bits, fragmentation, interleaved
// control frames and all three length encodings. They run under server and
// client mode and under size limits from the tightest to the widest. A
// built-in frame parser predicts every event, and a checker compares each
// output transfer with the oldest prediction. Random idle cycles fall on both
// channels, and a long receiver stall backs up the byte channel. The run ends
// with one randomly chosen fatal error and trailing bytes that must be ignored.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    localparam logic [63:0] LEN_MASK     = 64'h0000_0000_FFFF_FFFF;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [wsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [wsd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    wsd_rx_if rx_ch ();
    wsd_ev_if ev_ch ();

    websocket_frame_deframer #(
        .MSG_LEN_WIDTH(32)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_rx      (rx_ch),
        .o_ev      (ev_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register copies
    logic                           cfg_client;
    logic [wsd_pkg::CFG_DATA_W-1:0] cfg_max;

    // parser state
    wsd_pkg::t_phase ph;
    logic        fin;
    logic [3:0]  fop;
    logic        masked;
    logic [2:0]  cnt;
    logic [63:0] frm_left;
    logic [31:0] key;
    logic [1:0]  key_idx;
    logic [1:0]  msg_op;
    logic [63:0] msg_len;
    logic        closed;

    wsd_pkg::t_result pending_events[$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    bit      idle_on    = 1'b0;
    bit      hold_req   = 1'b0;
    int      hold_left  = 0;

    task automatic expect_event(input wsd_pkg::t_event ev, input logic [7:0] d,
                                input logic [1:0] op, input logic l);
        wsd_pkg::t_result r;
        r.ev   = ev;
        r.data = d;
        r.op   = op;
        r.last = l;
        pending_events.push_back(r);
    endtask

    task automatic open_payload;
        key_idx = 2'd0;
        if (frm_left != 64'd0) begin
            ph = wsd_pkg::PH_PAY;
            return;
        end
        ph = wsd_pkg::PH_HDR0;
        if (fop <= wsd_pkg::OP_DATA_MAX && fin) begin
            expect_event(wsd_pkg::EV_EMPTY_END, 8'h00, msg_op, 1'b1);
            msg_op  = 2'd0;
            msg_len = 64'd0;
        end
    endtask

    task automatic check_frame_len;
        logic [63:0] sum;
        if (fop <= wsd_pkg::OP_DATA_MAX) begin
            if (frm_left > (LEN_MASK - msg_len)) begin
                closed = 1'b1;
                expect_event(wsd_pkg::EV_TOO_LONG, 8'h00, 2'd0, 1'b0);
                return;
            end
            sum = msg_len + frm_left;
            if (sum >= {32'd0, cfg_max}) begin
                closed = 1'b1;
                expect_event(wsd_pkg::EV_TOO_LONG, 8'h00, 2'd0, 1'b0);
                return;
            end
            msg_len = sum;
        end
        if (masked) begin
            ph  = wsd_pkg::PH_KEY;
            cnt = 3'd3;
        end else begin
            open_payload();
        end
    endtask

    task automatic deframe_predict(input logic [7:0] b);
        logic [6:0]  code;
        logic [31:0] kb;
        logic [7:0]  plain;
        logic        last_b;
        if (closed)
            return;
        case (ph)
            wsd_pkg::PH_HDR0: begin
                fin = b[7];
                fop = b[3:0];
                ph  = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1: begin
                code    = b[6:0];
                masked  = b[7];
                key     = 32'd0;
                key_idx = 2'd0;
                if (fop > wsd_pkg::OP_DATA_MAX &&
                    (fop < wsd_pkg::OP_CLOSE || fop > wsd_pkg::OP_PONG)) begin
                    closed = 1'b1;
                    expect_event(wsd_pkg::EV_BAD_OPCODE, 8'h00, 2'd0, 1'b0);
                    return;
                end
                if (fop <= wsd_pkg::OP_DATA_MAX) begin
                    if (!cfg_client && !masked) begin
                        closed = 1'b1;
                        expect_event(wsd_pkg::EV_UNMASKED, 8'h00, 2'd0, 1'b0);
                        return;
                    end
                    if (fop != wsd_pkg::OP_CONT && msg_op == 2'd0)
                        msg_op = fop[1:0];
                end
                frm_left = 64'd0;
                if (code == wsd_pkg::LEN16_CODE) begin
                    cnt = 3'd1;
                    ph  = wsd_pkg::PH_EXT;
                end else if (code == wsd_pkg::LEN64_CODE) begin
                    cnt = 3'd7;
                    ph  = wsd_pkg::PH_EXT;
                end else begin
                    frm_left = {57'd0, code};
                    check_frame_len();
                end
                if (fop == wsd_pkg::OP_PING)
                    expect_event(wsd_pkg::EV_PONG, 8'h00, 2'd0, 1'b0);
            end
            wsd_pkg::PH_EXT: begin
                frm_left = {frm_left[55:0], b};
                if (cnt == 3'd0)
                    check_frame_len();
                else
                    cnt = cnt - 3'd1;
            end
            wsd_pkg::PH_KEY: begin
                key = {key[23:0], b};
                if (cnt == 3'd0)
                    open_payload();
                else
                    cnt = cnt - 3'd1;
            end
            wsd_pkg::PH_PAY: begin
                kb       = key >> (8 * (3 - key_idx));
                plain    = b ^ kb[7:0];
                key_idx  = key_idx + 2'd1;
                frm_left = frm_left - 64'd1;
                if (frm_left == 64'd0)
                    ph = wsd_pkg::PH_HDR0;
                if (fop <= wsd_pkg::OP_DATA_MAX) begin
                    last_b = fin && (frm_left == 64'd0);
                    expect_event(wsd_pkg::EV_DATA, plain, msg_op, last_b);
                    if (last_b) begin
                        msg_op  = 2'd0;
                        msg_len = 64'd0;
                    end
                end
            end
            default: ph = wsd_pkg::PH_HDR0;
        endcase
    endtask

    // byte acceptance feeds the parser, event transfers are checked in order
    always @(posedge i_clk) begin : ev_monitor
        wsd_pkg::t_result want;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready)
                deframe_predict(rx_ch.rx_byte);
            if (ev_ch.valid && ev_ch.ready) begin
                if (pending_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: event expected none actual ev %0d data %02h op %0d last %0b",
                             $time, ev_ch.event_res, ev_ch.data_byte,
                             ev_ch.message_opcode, ev_ch.last_of_message);
                end else begin
                    want = pending_events.pop_front();
                    if (ev_ch.event_res !== want.ev) begin
                        mismatches++;
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want.ev, ev_ch.event_res);
                    end
                    if (ev_ch.data_byte !== want.data) begin
                        mismatches++;
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data, ev_ch.data_byte);
                    end
                    if (ev_ch.message_opcode !== want.op) begin
                        mismatches++;
                        $display("%0t: message_opcode expected %0d actual %0d",
                                 $time, want.op, ev_ch.message_opcode);
                    end
                    if (ev_ch.last_of_message !== want.last) begin
                        mismatches++;
                        $display("%0t: last_of_message expected %0b actual %0b",
                                 $time, want.last, ev_ch.last_of_message);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            ev_ch.ready <= 1'b0;
        end else if (idle_on) begin
            ev_ch.ready <= ($urandom_range(0, 99) >= 33);
        end else begin
            ev_ch.ready <= 1'b1;
        end
    end

    // returns at the rising edge of the transfer, valid still high
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wsd_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wsd_pkg::CFG_IS_CLIENT)
            cfg_client = val[0];
        else
            cfg_max = val;
    endtask

    // form: 0 seven-bit length, 1 16-bit length, 2 64-bit length
    task automatic send_header(input bit fin_b, input logic [3:0] op, input bit mask_b,
                               input logic [63:0] len, input int form, input logic [31:0] mkey);
        logic [2:0] rsv;
        rsv = 3'($urandom_range(0, 7));
        send_byte({fin_b, rsv, op});
        if (form == 0) begin
            send_byte({mask_b, len[6:0]});
        end else if (form == 1) begin
            send_byte({mask_b, wsd_pkg::LEN16_CODE});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else begin
            send_byte({mask_b, wsd_pkg::LEN64_CODE});
            for (int i = 7; i >= 0; i--)
                send_byte(len[8*i +: 8]);
        end
        if (mask_b)
            for (int i = 3; i >= 0; i--)
                send_byte(mkey[8*i +: 8]);
    endtask

    task automatic send_frame(input bit fin_b, input logic [3:0] op, input bit mask_b,
                              input logic [63:0] len, input int form);
        send_header(fin_b, op, mask_b, len, form, $urandom);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame(input bit fin_b, input logic [3:0] op);
        logic [63:0] len;
        logic [63:0] room;
        int          form;
        int          pick;
        bit          mask_b;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = 64'($urandom_range(0, 12));
        else if (pick < 93)
            len = 64'($urandom_range(13, 40));
        else
            len = 64'($urandom_range(120, 300));
        if (op <= wsd_pkg::OP_DATA_MAX) begin
            room = {32'd0, cfg_max} - 64'd1 - msg_len;
            if (len > room)
                len = room;
            mask_b = cfg_client ? 1'($urandom_range(0, 1)) : 1'b1;
        end else begin
            mask_b = 1'($urandom_range(0, 1));
        end
        if (len < 126 && $urandom_range(0, 3) != 0)
            form = 0;
        else if ($urandom_range(0, 1) == 0)
            form = 1;
        else
            form = 2;
        send_frame(fin_b, op, mask_b, len, form);
    endtask

    task automatic send_random_message;
        int         nfrag;
        logic [3:0] op;
        logic [3:0] ctl;
        nfrag = $urandom_range(0, 3);
        op    = ($urandom_range(0, 4) == 0) ? wsd_pkg::OP_CONT : 4'($urandom_range(1, 2));
        for (int i = 0; i <= nfrag; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                ctl = wsd_pkg::OP_CLOSE + 4'($urandom_range(0, 2));
                send_random_frame(1'($urandom_range(0, 1)), ctl);
            end
            if (i != 0)
                op = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 2)) : wsd_pkg::OP_CONT;
            send_random_frame(i == nfrag, op);
        end
    endtask

    task automatic run_messages(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_message();
    endtask

    // reset register values, server mode
    task automatic test_server_frames;
        send_header(1'b1, 4'd1, 1'b1, 3, 0, 32'hFFFF_0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_frame(1'b0, 4'd2, 1'b1, 2, 1);
        send_frame(1'b1, wsd_pkg::OP_CONT, 1'b1, 1, 2);
        send_frame(1'b1, 4'd1, 1'b1, 0, 0);
        send_frame(1'b0, 4'd2, 1'b1, 0, 0);
        send_frame(1'b1, wsd_pkg::OP_PING, 1'b1, 2, 0);
        send_frame(1'b1, wsd_pkg::OP_CONT, 1'b1, 0, 1);
        send_frame(1'b1, wsd_pkg::OP_PONG, 1'b0, 1, 0);
        send_frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 0, 0);
        send_frame(1'b1, wsd_pkg::OP_CONT, 1'b1, 1, 0);
        send_frame(1'b0, wsd_pkg::OP_PING, 1'b0, 0, 2);
        wait_drained();
    endtask

    task automatic test_client_frames;
        write_reg(wsd_pkg::CFG_IS_CLIENT, 32'd1);
        send_frame(1'b0, 4'd1, 1'b0, 2, 0);
        send_frame(1'b1, wsd_pkg::OP_CONT, 1'b1, 1, 0);
        send_frame(1'b1, 4'd2, 1'b0, 0, 2);
        wait_drained();
    endtask

    // a limit of one lets only empty data frames through
    task automatic test_tightest_limit;
        write_reg(wsd_pkg::CFG_MAX_MSG, 32'd1);
        send_frame(1'b1, 4'd1, 1'b0, 0, 0);
        send_frame(1'b1, wsd_pkg::OP_PING, 1'b1, 3, 1);
        send_frame(1'b0, 4'd2, 1'b1, 0, 0);
        send_frame(1'b1, wsd_pkg::OP_CONT, 1'b0, 0, 2);
        wait_drained();
        write_reg(wsd_pkg::CFG_MAX_MSG, wsd_pkg::MAX_MSG_RESET);
    endtask

    task automatic test_output_stall;
        idle_on  = 1'b0;
        hold_req = 1'b1;
        run_messages(100);
        wait_drained();
    endtask

    task automatic test_random_traffic;
        write_reg(wsd_pkg::CFG_MAX_MSG, 32'hFFFF_FFFF);
        idle_on = 1'b0;
        run_messages(180);
        wait_drained();
        write_reg(wsd_pkg::CFG_IS_CLIENT, 32'd0);
        write_reg(wsd_pkg::CFG_MAX_MSG, wsd_pkg::MAX_MSG_RESET);
        idle_on = 1'b1;
        run_messages(220);
        wait_drained();
        write_reg(wsd_pkg::CFG_IS_CLIENT, 32'd1);
        write_reg(wsd_pkg::CFG_MAX_MSG, $urandom_range(20, 200));
        run_messages(150);
        wait_drained();
        write_reg(wsd_pkg::CFG_IS_CLIENT, $urandom_range(0, 1));
        write_reg(wsd_pkg::CFG_MAX_MSG, $urandom_range(300, 5000));
        run_messages(150);
        wait_drained();
    endtask

    // one fatal error per run, then the block must stay silent
    task automatic test_fatal_error;
        int          pick;
        logic [3:0]  bad_op;
        logic [63:0] len;
        pick = $urandom_range(0, 4);
        case (pick)
            0: begin
                bad_op = 4'($urandom_range(3, 12));
                if (bad_op > 4'd7)
                    bad_op = bad_op + 4'd3;
                send_header(1'($urandom_range(0, 1)), bad_op, 1'b1, 0, 0, $urandom);
            end
            1: begin
                write_reg(wsd_pkg::CFG_IS_CLIENT, 32'd0);
                send_header(1'b1, 4'($urandom_range(1, 2)), 1'b0, 5, 0, 32'd0);
            end
            2: begin
                write_reg(wsd_pkg::CFG_MAX_MSG, $urandom_range(1, 64));
                len = {32'd0, cfg_max} + 64'($urandom_range(0, 3));
                send_header(1'b1, 4'($urandom_range(0, 2)), 1'b1, len, 1, $urandom);
            end
            3: begin
                write_reg(wsd_pkg::CFG_MAX_MSG, 32'hFFFF_FFFF);
                len     = {$urandom, $urandom};
                len[63] = 1'b1;
                send_header(1'b1, 4'd2, 1'b1, len, 2, $urandom);
            end
            default: begin
                write_reg(wsd_pkg::CFG_MAX_MSG, 32'd0);
                send_header(1'b1, 4'd1, 1'b1, 0, 0, $urandom);
            end
        endcase
        repeat (24) send_byte(8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = wsd_pkg::CFG_IS_CLIENT;
        i_cfg_data    = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        ev_ch.ready   = 1'b0;
        cfg_client    = 1'b0;
        cfg_max       = wsd_pkg::MAX_MSG_RESET;
        ph            = wsd_pkg::PH_HDR0;
        fin           = 1'b0;
        fop           = 4'd0;
        masked        = 1'b0;
        cnt           = 3'd0;
        frm_left      = 64'd0;
        key           = 32'd0;
        key_idx       = 2'd0;
        msg_op        = 2'd0;
        msg_len       = 64'd0;
        closed        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_server_frames();
        test_client_frames();
        test_tightest_limit();
        test_output_stall();
        test_random_traffic();
        test_fatal_error();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/wsd_pkg.sv
design/wsd_rx_if.sv
design/wsd_ev_if.sv
design/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
